// ===== rtl/rsfd_pkg.sv =====
// ----------------------------------------------------------------------------
// rsfd_pkg
// Shared types and constants for the run-length sprite frame decoder.
// ----------------------------------------------------------------------------
package rsfd_pkg;

   localparam int MAX_WIDTH     = 256;
   localparam int MAX_HEIGHT    = 256;
   localparam int PALETTE_DEPTH = 256;
   localparam int ROW_LIMIT     = 256;

   localparam int REQ_TDATA_BITS = 40;
   localparam int REQ_TUSER_BITS = 2;
   localparam int RSP_TDATA_BITS = 48;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam int FRAME_DIM_BITS = 9;
   localparam int COLUMN_BITS    = 10;
   localparam int ROW_BITS       = 8;
   localparam int RUN_BITS       = 7;
   localparam int RGB_BITS       = 24;
   localparam int ADDR_BITS      = 16;

   localparam int WIDTH_CAP_INT  = (MAX_WIDTH > 511) ? 511 : MAX_WIDTH;
   localparam int HEIGHT_CAP_INT = (MAX_HEIGHT > ROW_LIMIT) ? ROW_LIMIT : MAX_HEIGHT;
   localparam logic [FRAME_DIM_BITS-1:0] WIDTH_CAP  = FRAME_DIM_BITS'(WIDTH_CAP_INT);
   localparam logic [FRAME_DIM_BITS-1:0] HEIGHT_CAP = FRAME_DIM_BITS'(HEIGHT_CAP_INT);

   localparam logic [7:0] CODE_ROW_END   = 8'h80;
   localparam logic [7:0] CODE_SKIP_MASK = 8'h7F;
   localparam logic [7:0] ALPHA_OPAQUE   = 8'hFF;
   localparam logic [COLUMN_BITS-1:0] COLUMN_MAX = 10'd1023;

   typedef enum logic [1:0] {
      REQ_PALETTE = 2'd0,
      REQ_START   = 2'd1,
      REQ_DATA    = 2'd2
   } req_kind_type;

   typedef enum logic {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } csr_reg_type;

endpackage

// ===== rtl/rsfd_ram.sv =====
// ----------------------------------------------------------------------------
// rsfd_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module rsfd_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rle_sprite_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// rle_sprite_frame_decoder
// Decodes a bottom-up, run-length coded, paletted sprite frame one byte per
// transfer and emits one opaque ARGB pixel write per literal within the row width.
//
//   Channel  Direction  Payload
//   req_     in         tuser: req_type; tdata: code_byte, palette_index,
//                       palette_rgb
//   rsp_     out        tdata: pixel_address, pixel_color
//   csr_     in         APB registers frame_width (0x0), frame_height (0x4)
//
// One request transfer is taken per cycle when the output side keeps up.
// A pixel reaches rsp_ through the palette memory's registered read and then
// the output register.
// A two-entry output register and skid buffer absorb rsp_ stalls.
// Reset clears the position state and ends any frame; palette entries are
// undefined until written.
// ----------------------------------------------------------------------------
module rle_sprite_frame_decoder (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [7:0] code_byte, [15:8] palette_index, [39:16] palette_rgb
   input  logic [rsfd_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // [1:0] req_type
   input  logic [rsfd_pkg::REQ_TUSER_BITS-1:0] req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [15:0] pixel_address, [47:16] pixel_color
   output logic [rsfd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rsfd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [rsfd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [rsfd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                                csr_pready
);

   import rsfd_pkg::*;

   localparam int PAL_ADDR_BITS = $clog2(PALETTE_DEPTH);

   logic [FRAME_DIM_BITS-1:0] frame_width_ff;
   logic [FRAME_DIM_BITS-1:0] frame_height_ff;
   logic [COLUMN_BITS-1:0]    column_ff;
   logic [COLUMN_BITS-1:0]    column_in;
   logic [ROW_BITS-1:0]       row_ff;
   logic [ROW_BITS-1:0]       row_in;
   logic [RUN_BITS-1:0]       run_left_ff;
   logic [RUN_BITS-1:0]       run_left_in;
   logic                      dropping_run_ff;
   logic                      dropping_run_in;
   logic                      frame_done_ff;
   logic                      frame_done_in;

   logic                      p_valid_ff;
   logic                      p_valid_in;
   logic [ADDR_BITS-1:0]      p_addr_ff;
   logic [ADDR_BITS-1:0]      p_addr_in;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [RSP_TDATA_BITS-1:0] rsp_data_ff;
   logic [RSP_TDATA_BITS-1:0] rsp_data_in;
   logic                      skid_valid_ff;
   logic                      skid_valid_in;
   logic [RSP_TDATA_BITS-1:0] skid_data_ff;
   logic [RSP_TDATA_BITS-1:0] skid_data_in;

   logic                      req_fire;
   logic                      csr_write;
   csr_reg_type               csr_reg;
   req_kind_type              req_kind;
   logic [7:0]                code_byte;
   logic [PAL_ADDR_BITS-1:0]  palette_index;
   logic [RGB_BITS-1:0]       palette_rgb;
   logic [FRAME_DIM_BITS-1:0] used_width;
   logic [FRAME_DIM_BITS-1:0] used_height;
   logic [COLUMN_BITS:0]      skip_sum;
   logic [16:0]               row_product;
   logic [16:0]               address_sum;
   logic                      pal_wr_en;
   logic                      pal_rd_en;
   logic [RGB_BITS-1:0]       pal_rd_data;
   logic [RSP_TDATA_BITS-1:0] p_item;
   logic                      out_free;

   assign req_fire      = req_tvalid && req_tready;
   assign req_kind      = req_kind_type'(req_tuser);
   assign code_byte     = req_tdata[7:0];
   assign palette_index = req_tdata[15:8];
   assign palette_rgb   = req_tdata[39:16];

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_reg    = csr_reg_type'(csr_paddr[2]);

   always_comb begin
      case (csr_reg)
         REG_FRAME_WIDTH: begin
            csr_prdata = CSR_DATA_BITS'(frame_width_ff);
         end
         REG_FRAME_HEIGHT: begin
            csr_prdata = CSR_DATA_BITS'(frame_height_ff);
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   assign used_width  = (frame_width_ff > WIDTH_CAP) ? WIDTH_CAP : frame_width_ff;
   assign used_height = (frame_height_ff > HEIGHT_CAP) ? HEIGHT_CAP : frame_height_ff;
   assign skip_sum    = {1'b0, column_ff} + (COLUMN_BITS + 1)'(code_byte & CODE_SKIP_MASK);
   assign row_product = 17'(row_ff) * 17'(used_width);
   assign address_sum = row_product + 17'(column_ff);

   always_comb begin
      column_in       = column_ff;
      row_in          = row_ff;
      run_left_in     = run_left_ff;
      dropping_run_in = dropping_run_ff;
      frame_done_in   = frame_done_ff;
      pal_wr_en       = 1'b0;
      pal_rd_en       = 1'b0;
      p_valid_in      = 1'b0;
      p_addr_in       = address_sum[ADDR_BITS-1:0];
      if (req_fire) begin
         case (req_kind)
            REQ_PALETTE: begin
               pal_wr_en = 1'b1;
            end
            REQ_START: begin
               column_in       = '0;
               run_left_in     = '0;
               dropping_run_in = 1'b0;
               if (used_height == '0) begin
                  row_in        = '0;
                  frame_done_in = 1'b1;
               end else begin
                  row_in        = ROW_BITS'(used_height - 1'b1);
                  frame_done_in = 1'b0;
               end
            end
            REQ_DATA: begin
               if (!frame_done_ff) begin
                  if (run_left_ff != '0) begin
                     run_left_in = run_left_ff - 1'b1;
                     if (!dropping_run_ff) begin
                        if ({1'b0, column_ff} >= (COLUMN_BITS + 1)'(used_width)) begin
                           dropping_run_in = 1'b1;
                        end else begin
                           pal_rd_en  = 1'b1;
                           p_valid_in = 1'b1;
                           column_in  = column_ff + 1'b1;
                        end
                     end
                  end else if (code_byte == CODE_ROW_END) begin
                     column_in = '0;
                     if (row_ff == '0) begin
                        frame_done_in = 1'b1;
                     end else begin
                        row_in = row_ff - 1'b1;
                     end
                  end else if (code_byte[7]) begin
                     if (skip_sum > (COLUMN_BITS + 1)'(COLUMN_MAX)) begin
                        column_in = COLUMN_MAX;
                     end else begin
                        column_in = skip_sum[COLUMN_BITS-1:0];
                     end
                  end else begin
                     run_left_in     = code_byte[RUN_BITS-1:0];
                     dropping_run_in = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   rsfd_ram #(
      .WIDTH (RGB_BITS),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (palette_index),
      .wr_data (palette_rgb),
      .rd_en   (pal_rd_en),
      .rd_addr (code_byte),
      .rd_data (pal_rd_data)
   );

   assign p_item   = {ALPHA_OPAQUE, pal_rd_data, p_addr_ff};
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_data_in   = skid_data_ff;
            skid_valid_in = p_valid_ff;
            skid_data_in  = p_item;
         end else begin
            rsp_valid_in = p_valid_ff;
            rsp_data_in  = p_item;
         end
      end else if (p_valid_ff) begin
         skid_valid_in = 1'b1;
         skid_data_in  = p_item;
      end
   end

   assign req_tready = !skid_valid_ff && !(p_valid_ff && rsp_valid_ff && !rsp_tready);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= '0;
         frame_height_ff <= '0;
         column_ff       <= '0;
         row_ff          <= '0;
         run_left_ff     <= '0;
         dropping_run_ff <= 1'b0;
         frame_done_ff   <= 1'b1;
         p_valid_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         skid_valid_ff   <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_reg)
               REG_FRAME_WIDTH: begin
                  frame_width_ff <= csr_pwdata[FRAME_DIM_BITS-1:0];
               end
               REG_FRAME_HEIGHT: begin
                  frame_height_ff <= csr_pwdata[FRAME_DIM_BITS-1:0];
               end
               default: begin
               end
            endcase
         end
         column_ff       <= column_in;
         row_ff          <= row_in;
         run_left_ff     <= run_left_in;
         dropping_run_ff <= dropping_run_in;
         frame_done_ff   <= frame_done_in;
         p_valid_ff      <= p_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
         skid_valid_ff   <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_addr_ff    <= p_addr_in;
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   a_skid_behind_output: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid buffer holds a pixel while the output register is empty");

   a_pixel_from_data: assert property (@(posedge clock) disable iff (reset)
      p_valid_in |-> (req_fire && req_kind == REQ_DATA && !frame_done_ff))
      else $error("pixel issued without an accepted coded byte");

   a_run_inside_frame: assert property (@(posedge clock) disable iff (reset)
      (run_left_ff != '0) |-> !frame_done_ff)
      else $error("literal run pending after the frame ended");

   a_no_pixel_overflow: assert property (@(posedge clock) disable iff (reset)
      (p_valid_ff && rsp_valid_ff && !rsp_tready) |-> !skid_valid_ff)
      else $error("pixel arrived with no free output slot");

   a_opaque_alpha: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff[RSP_TDATA_BITS-1 -: 8] == ALPHA_OPAQUE))
      else $error("output pixel is not opaque");

endmodule

// ===== bench/rsfd_pixel_checker.sv =====
// ----------------------------------------------------------------------------
// Pixel write checker for the run-length sprite frame decoder
// Watches the request, result and register ports, tracks the palette,
// frame position and register values on its own, works out the pixel write
// (if any) each accepted request should cause, and compares every result transfer
// against the oldest pixel write still awaited.
// ----------------------------------------------------------------------------
module rsfd_pixel_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [rsfd_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   input  logic [rsfd_pkg::REQ_TUSER_BITS-1:0] req_tuser,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [rsfd_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rsfd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [rsfd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   input  logic                                csr_pready,
   output int                                  failures,
   output int                                  pixels_pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rsfd_pkg::*;

   typedef struct packed {
      logic [31:0]          color;
      logic [ADDR_BITS-1:0] address;
   } pixel_write_type;

   logic [RGB_BITS-1:0]       palette_rgb_store [PALETTE_DEPTH];
   logic [COLUMN_BITS-1:0]    column;
   logic [ROW_BITS-1:0]       row;
   logic [RUN_BITS-1:0]       run_left;
   logic                      dropping_run;
   logic                      frame_done;
   logic [FRAME_DIM_BITS-1:0] frame_width;
   logic [FRAME_DIM_BITS-1:0] frame_height;
   pixel_write_type           expected_pixels [$];
   int                        error_count = 0;

   function automatic void clear_decoder();
      foreach (palette_rgb_store[i]) palette_rgb_store[i] = '0;
      column = '0;
      row = '0;
      run_left = '0;
      dropping_run = 1'b0;
      frame_done = 1'b1;
      frame_width = '0;
      frame_height = '0;
   endfunction

   function automatic bit decode_request(input logic [1:0] kind, input logic [7:0] code,
                                         input logic [7:0] index, input logic [23:0] rgb,
                                         output pixel_write_type px);
      int  w;
      int  h;
      int  skipped;
      bit  produced;
      produced = 1'b0;
      px = '0;
      w = (int'(frame_width) > MAX_WIDTH) ? MAX_WIDTH : int'(frame_width);
      h = (int'(frame_height) > MAX_HEIGHT) ? MAX_HEIGHT : int'(frame_height);
      if (h > ROW_LIMIT) h = ROW_LIMIT;
      if (kind == REQ_PALETTE) begin
         palette_rgb_store[index] = rgb;
      end else if (kind == REQ_START) begin
         column = '0;
         run_left = '0;
         dropping_run = 1'b0;
         if (h == 0) begin
            row = '0;
            frame_done = 1'b1;
         end else begin
            row = ROW_BITS'(h - 1);
            frame_done = 1'b0;
         end
      end else if (kind == REQ_DATA && !frame_done) begin
         if (run_left != 0) begin
            run_left = run_left - 1'b1;
            if (!dropping_run) begin
               if (int'(column) >= w) begin
                  dropping_run = 1'b1;
               end else begin
                  px.address = ADDR_BITS'(int'(row) * w + int'(column));
                  px.color = {ALPHA_OPAQUE, palette_rgb_store[code]};
                  column = column + 1'b1;
                  produced = 1'b1;
               end
            end
         end else if (code == CODE_ROW_END) begin
            column = '0;
            if (row == 0) frame_done = 1'b1;
            else row = row - 1'b1;
         end else if (code[7]) begin
            skipped = int'(column) + int'(code & CODE_SKIP_MASK);
            column = (skipped > int'(COLUMN_MAX)) ? COLUMN_MAX : COLUMN_BITS'(skipped);
         end else begin
            run_left = code[RUN_BITS-1:0];
            dropping_run = 1'b0;
         end
      end
      return produced;
   endfunction

   always @(posedge clock) begin : watch
      pixel_write_type got;
      pixel_write_type want;
      pixel_write_type px;
      if (reset) begin
         clear_decoder();
         expected_pixels.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (expected_pixels.size() == 0) begin
               error_count++;
               $error("pixel write with none awaited: pixel_address %h pixel_color %h",
                      got.address, got.color);
            end else begin
               want = expected_pixels.pop_front();
               if (got.address !== want.address) begin
                  error_count++;
                  $error("pixel_address expected %h actual %h", want.address, got.address);
               end
               if (got.color !== want.color) begin
                  error_count++;
                  $error("pixel_color expected %h actual %h", want.color, got.color);
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_FRAME_WIDTH) frame_width = csr_pwdata[FRAME_DIM_BITS-1:0];
            else frame_height = csr_pwdata[FRAME_DIM_BITS-1:0];
         end
         if (req_tvalid && req_tready) begin
            if (decode_request(req_tuser, req_tdata[7:0], req_tdata[15:8], req_tdata[39:16], px))
               expected_pixels.push_back(px);
         end
      end
      pixels_pending <= expected_pixels.size();
      failures <= error_count;
   end

endmodule

// ===== bench/rle_sprite_frame_decoder_tb.sv =====
// ----------------------------------------------------------------------------
// Testbench for the run-length sprite frame decoder
// Fills the palette, runs a short set of hand-made frames that reach the
// row, column and register extremes, then codes random frames under random
// register settings with noise and aborted frames mixed in. The request side
// sends in bursts and the result side stalls on its own pattern, with at
// least one long hold-off that backs the decoder up. A separate checker
// predicts and compares the pixel writes.
// ----------------------------------------------------------------------------
module rle_sprite_frame_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rsfd_pkg::*;

   localparam logic [1:0] REQ_UNKNOWN     = 2'd3;
   localparam int         RANDOM_REQUESTS = 700;
   localparam int         DRAIN_CYCLES    = 8;
   localparam int         CYCLE_LIMIT     = 2000000;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata = '0;
   logic [REQ_TUSER_BITS-1:0] req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;
   int                        failures;
   int                        pixels_pending;

   int cycle_count = 0;
   int burst_left = 0;
   int requests_sent = 0;
   int cfg_width = 0;
   int cfg_height = 0;
   bit stress_armed = 1'b0;
   bit stress_done = 1'b0;

   rle_sprite_frame_decoder dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   rsfd_pixel_checker pixel_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .failures(failures), .pixels_pending(pixels_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin : rsp_stall_pattern
      int mode;
      int span;
      forever begin
         if (stress_armed && !stress_done && rsp_tvalid) begin
            rsp_tready <= 1'b0;
            repeat (400) @(posedge clock);
            stress_done = 1'b1;
         end else begin
            mode = $urandom_range(0, 19);
            span = (mode == 19) ? $urandom_range(100, 300) : $urandom_range(8, 60);
            repeat (span) begin
               if (mode < 10) rsp_tready <= 1'b1;
               else if (mode < 16) rsp_tready <= ($urandom_range(0, 2) != 0);
               else if (mode < 19) rsp_tready <= ($urandom_range(0, 2) == 0);
               else rsp_tready <= 1'b0;
               @(posedge clock);
            end
         end
      end
   end

   task automatic send_request(input logic [1:0] kind, input logic [7:0] code,
                               input logic [7:0] index, input logic [23:0] rgb);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                  : $urandom_range(1, 16);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {rgb, index, code};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      requests_sent++;
   endtask

   task automatic send_code(input logic [7:0] code);
      send_request(REQ_DATA, code, 8'($urandom), 24'($urandom));
   endtask

   task automatic send_literals(input int count);
      repeat (count) send_code(8'($urandom));
   endtask

   task automatic send_noise();
      case ($urandom_range(0, 2))
         0: send_request(REQ_PALETTE, 8'($urandom), 8'($urandom), 24'($urandom));
         1: send_request(REQ_UNKNOWN, 8'($urandom), 8'($urandom), 24'($urandom));
         default: send_request(REQ_START, 8'($urandom), 8'($urandom), 24'($urandom));
      endcase
   endtask

   task automatic code_frame(input int rows_coded, input int cols);
      int col;
      int n;
      int segments;
      send_request(REQ_START, 8'($urandom), 8'($urandom), 24'($urandom));
      for (int r = 0; r < rows_coded; r++) begin
         col = 0;
         segments = $urandom_range(0, 4);
         repeat (segments) begin
            if ($urandom_range(0, 24) == 0) send_noise();
            case ($urandom_range(0, 9))
               0: send_code(8'h00);
               1, 2, 3: begin
                  n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 4);
                  send_code(CODE_ROW_END | 8'(n));
                  col += n;
               end
               default: begin
                  n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 127)
                      : $urandom_range(1, ((cols > col) ? cols - col : 0) + 2);
                  if (n > 127) n = 127;
                  send_code(8'(n));
                  send_literals(n);
                  col += n;
               end
            endcase
         end
         send_code(CODE_ROW_END);
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input csr_reg_type which, input int value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {which, 2'b00};
      csr_pwdata <= CSR_DATA_BITS'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
   endtask

   task automatic set_frame(input int width, input int height);
      wait_idle();
      csr_write(REG_FRAME_WIDTH, width);
      csr_write(REG_FRAME_HEIGHT, height);
      cfg_width = width;
      cfg_height = height;
   endtask

   function automatic int extreme_dim();
      case ($urandom_range(0, 3))
         0: return 0;
         1: return 256;
         2: return 300;
         default: return 511;
      endcase
   endfunction

   initial begin : stimulus
      int target;
      int used_w;
      int used_h;
      int rows;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < PALETTE_DEPTH; i++)
         send_request(REQ_PALETTE, 8'($urandom), 8'(i),
                      (i == 0) ? 24'h000000 : (i == 255) ? 24'hFFFFFF : 24'($urandom));

      set_frame(4, 2);
      send_request(REQ_START, 8'hFF, 8'hFF, 24'hFFFFFF);
      send_code(8'h00);
      send_code(8'h02);
      send_literals(2);
      send_code(8'h81);
      send_code(8'h03);
      send_literals(3);
      send_code(CODE_ROW_END);
      repeat (9) send_code(8'hFF);
      send_code(8'h01);
      send_literals(1);
      send_code(CODE_ROW_END);
      send_code(8'h05);
      send_request(REQ_UNKNOWN, 8'hFF, 8'hFF, 24'hFFFFFF);

      set_frame(511, 511);
      send_request(REQ_START, 8'h00, 8'h00, 24'h000000);
      send_code(8'hFF);
      send_code(8'hFF);
      send_code(8'h04);
      send_literals(4);
      send_request(REQ_START, 8'($urandom), 8'($urandom), 24'($urandom));

      set_frame(0, 0);
      send_request(REQ_START, 8'($urandom), 8'($urandom), 24'($urandom));
      send_code(8'h01);
      send_literals(1);

      set_frame(0, 1);
      send_request(REQ_START, 8'($urandom), 8'($urandom), 24'($urandom));
      send_code(8'h02);
      send_literals(2);
      send_code(CODE_ROW_END);
      send_code(8'h03);

      stress_armed = 1'b1;
      target = requests_sent + RANDOM_REQUESTS;
      while (requests_sent < target) begin
         case ($urandom_range(0, 9))
            0: set_frame(extreme_dim(), $urandom_range(1, 6));
            1: set_frame($urandom_range(1, 16), extreme_dim());
            default: set_frame($urandom_range(1, 16), $urandom_range(1, 6));
         endcase
         used_w = (cfg_width > MAX_WIDTH) ? MAX_WIDTH : cfg_width;
         used_h = (cfg_height > ROW_LIMIT) ? ROW_LIMIT : cfg_height;
         repeat ($urandom_range(1, 3)) begin
            rows = (used_h > 6) ? $urandom_range(1, 6) : used_h;
            if (rows > 0 && $urandom_range(0, 7) == 0) rows = $urandom_range(0, rows - 1);
            code_frame(rows, used_w);
            repeat ($urandom_range(0, 3)) send_code(8'($urandom));
         end
      end

      wait_idle();
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/rsfd_pkg.sv
rtl/rsfd_ram.sv
rtl/rle_sprite_frame_decoder.sv
bench/rsfd_pixel_checker.sv
bench/rle_sprite_frame_decoder_tb.sv
